FILE: rtl/pbde_pkg.sv
// Shared types, codes and helper functions of the packed bitmap draw engine.
package pbde_pkg;

    // Default geometry of the word store.
    localparam int unsigned MAX_ROW_WORDS_DEF = 32;
    localparam int unsigned MAX_ROWS_DEF      = 1024;

    // Configuration port geometry.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_WORDS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS = 2'd3;

    // Command mode codes.
    localparam logic [2:0] MODE_SET     = 3'd0;
    localparam logic [2:0] MODE_GET     = 3'd1;
    localparam logic [2:0] MODE_SPAN    = 3'd2;
    localparam logic [2:0] MODE_COMBINE = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    // Raster operation codes.
    localparam logic [2:0] ROP_COPY = 3'd0;
    localparam logic [2:0] ROP_OR   = 3'd1;
    localparam logic [2:0] ROP_AND  = 3'd2;
    localparam logic [2:0] ROP_XOR  = 3'd3;
    localparam logic [2:0] ROP_ANDN = 3'd4;
    localparam logic [2:0] ROP_NOT  = 3'd5;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    // Decoded command class.
    typedef enum logic [2:0] {
        K_NONE,
        K_SET,
        K_GET,
        K_SPAN,
        K_COMBINE,
        K_CLEAR
    } t_kind;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WORD,
        S_SPAN,
        S_CLEAR
    } t_state;

    // Command as handed from the decoder to the sequencer.
    typedef struct packed {
        t_kind       kind;
        logic        reject;
        logic [4:0]  bit_pos;   // pixel position inside the word, 0 is the MSB
        logic        pix;
        logic [31:0] src;
        logic [2:0]  rop;
        logic [4:0]  lo;        // first pixel of the span in its first word
        logic [4:0]  hm;        // last pixel of the span in its last word
        logic [5:0]  touched;
    } t_cmd;

    // Apply a raster operation to a stored word.
    function automatic logic [31:0] rop_apply(input logic [2:0] op, input logic [31:0] dst,
                                              input logic [31:0] src);
        logic [31:0] res;
        unique case (op)
            ROP_COPY: res = src;
            ROP_OR:   res = dst | src;
            ROP_AND:  res = dst & src;
            ROP_XOR:  res = dst ^ src;
            ROP_ANDN: res = dst & ~src;
            ROP_NOT:  res = ~src;
            default:  res = dst;
        endcase
        return res;
    endfunction

    // Ones at pixels lo through hm of a word, leftmost pixel in the MSB.
    function automatic logic [31:0] span_mask(input logic [4:0] lo, input logic [4:0] hm);
        logic [31:0] head;
        logic [31:0] tail;
        head = ALL_ONES >> lo;
        tail = ALL_ONES << (5'd31 - hm);
        return head & tail;
    endfunction

endpackage

FILE: rtl/pbde_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pbde_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pbde_decode.sv
// Command decoder: bounds checks, span clipping and word address of an incoming command.
module pbde_decode #(
    parameter int unsigned MAX_ROW_WORDS = pbde_pkg::MAX_ROW_WORDS_DEF,
    parameter int unsigned MAX_ROWS      = pbde_pkg::MAX_ROWS_DEF,
    localparam int unsigned DEPTH = MAX_ROWS * MAX_ROW_WORDS,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned WIW   = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
) (
    input  logic [11:0]        i_origin_x,
    input  logic [11:0]        i_origin_y,
    input  logic [5:0]         i_width_words,
    input  logic [10:0]        i_height_rows,
    input  logic [2:0]         i_mode,
    input  logic [12:0]        i_pos_x,
    input  logic [12:0]        i_pos_y,
    input  logic signed [11:0] i_span_length,
    input  logic               i_pixel_value,
    input  logic [31:0]        i_source_word,
    input  logic [2:0]         i_raster_op,
    output pbde_pkg::t_cmd     o_cmd,
    output logic [AW-1:0]      o_addr,
    output logic [WIW-1:0]     o_span_count
);

    import pbde_pkg::*;

    logic [5:0]  eff_w;
    logic [10:0] eff_h;
    logic [12:0] wpx;
    logic [13:0] rx;
    logic [13:0] ry;
    logic        x_ok;
    logic        y_ok;
    logic        len_ok;
    logic [12:0] rxc;
    logic        span_ok;
    logic [12:0] end_x;
    logic [12:0] end_c;
    logic [12:0] end_m1;
    logic [7:0]  first_w;
    logic [7:0]  last_w;
    logic [7:0]  end_w;
    logic [7:0]  word_sel;
    logic        rop_ok;
    t_kind       kind;
    logic        reject;

    // Geometry in use, limited to the size of the store.
    assign eff_w = (32'(i_width_words) > MAX_ROW_WORDS) ? 6'(MAX_ROW_WORDS) : i_width_words;
    assign eff_h = (32'(i_height_rows) > MAX_ROWS) ? 11'(MAX_ROWS) : i_height_rows;
    assign wpx   = {2'b00, eff_w, 5'b00000};

    // Bitmap coordinates relative to the origin; bit 13 is the sign.
    assign rx = {1'b0, i_pos_x} - {2'b00, i_origin_x};
    assign ry = {1'b0, i_pos_y} - {2'b00, i_origin_y};

    assign x_ok = !rx[13] && (rx[12:0] < wpx);
    assign y_ok = !ry[13] && (ry[12:0] < {2'b00, eff_h});

    // Span: clip the start to the left edge and the end to the row's end.
    assign len_ok  = !i_span_length[11] && (i_span_length != 12'sd0);
    assign rxc     = rx[13] ? 13'd0 : rx[12:0];
    assign span_ok = y_ok && len_ok && (rxc < wpx);
    assign end_x   = rxc + {2'b00, i_span_length[10:0]};
    assign end_c   = (end_x >= wpx) ? wpx : end_x;
    assign end_m1  = end_c - 13'd1;
    assign first_w = rxc[12:5];
    assign last_w  = end_m1[12:5];
    assign end_w   = end_c[12:5];

    assign rop_ok = (i_raster_op <= ROP_NOT);

    // Command class and rejection.
    always_comb begin
        unique case (i_mode)
            MODE_SET: begin
                kind   = K_SET;
                reject = !(x_ok && y_ok);
            end
            MODE_GET: begin
                kind   = K_GET;
                reject = !(x_ok && y_ok);
            end
            MODE_SPAN: begin
                kind   = K_SPAN;
                reject = !span_ok;
            end
            MODE_COMBINE: begin
                kind   = K_COMBINE;
                reject = !(x_ok && y_ok && rop_ok);
            end
            MODE_CLEAR: begin
                kind   = K_CLEAR;
                reject = 1'b0;
            end
            default: begin
                kind   = K_NONE;
                reject = 1'b1;
            end
        endcase
    end

    // Word address: row base plus word within the row.
    assign word_sel = (kind == K_SPAN) ? first_w : rx[12:5];
    assign o_addr   = AW'(32'(ry[12:0]) * 32'(MAX_ROW_WORDS) + 32'(word_sel));

    assign o_span_count = WIW'(last_w - first_w);

    always_comb begin
        o_cmd.kind    = kind;
        o_cmd.reject  = reject;
        o_cmd.bit_pos = rx[4:0];
        o_cmd.pix     = i_pixel_value;
        o_cmd.src     = i_source_word;
        o_cmd.rop     = i_raster_op;
        o_cmd.lo      = rxc[4:0];
        o_cmd.hm      = end_m1[4:0];
        o_cmd.touched = (end_w > first_w) ? 6'(end_w - first_w - 8'd1) : 6'd0;
    end

endmodule

FILE: rtl/pbde_ctrl.sv
// Sequencer: read-modify-write of the word store, span walk, clearing sweep and result register.
module pbde_ctrl #(
    parameter int unsigned MAX_ROW_WORDS = pbde_pkg::MAX_ROW_WORDS_DEF,
    parameter int unsigned MAX_ROWS      = pbde_pkg::MAX_ROWS_DEF,
    localparam int unsigned DEPTH = MAX_ROWS * MAX_ROW_WORDS,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned WIW   = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pbde_pkg::t_cmd i_cmd,
    input  logic [AW-1:0]  i_addr,
    input  logic [WIW-1:0] i_span_count,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_read_bit,
    output logic           o_status,
    output logic [5:0]     o_words_touched
);

    import pbde_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state         r_state, n_state;
    logic [AW-1:0]  r_addr, n_addr;
    logic [WIW-1:0] r_left, n_left;
    logic           r_first_word, n_first_word;
    t_cmd           r_cmd, n_cmd;
    logic           r_out_valid, n_out_valid;
    logic           r_read_bit, n_read_bit;
    logic           r_status, n_status;
    logic [5:0]     r_touched, n_touched;

    logic           slot_free;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [31:0]    wr_data;
    logic [31:0]    rd_data;
    logic [4:0]     sh;
    logic [31:0]    bit_m;
    logic [31:0]    word_res;
    logic           last_word;
    logic [31:0]    fill_m;

    // Word store.
    pbde_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign slot_free = !r_out_valid || !i_out_stall;

    // Modified word for single pixel and combine commands.
    assign sh    = ~r_cmd.bit_pos;
    assign bit_m = 32'd1 << sh;
    assign word_res = (r_cmd.kind == K_SET)
                    ? ((rd_data & ~bit_m) | (r_cmd.pix ? bit_m : 32'd0))
                    : rop_apply(r_cmd.rop, rd_data, r_cmd.src);

    // Mask of the span word at hand.
    assign last_word = (r_left == '0);
    assign fill_m    = span_mask(r_first_word ? r_cmd.lo : 5'd0,
                                 last_word ? r_cmd.hm : 5'd31);

    // State and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_first_word <= n_first_word;
        r_cmd        <= n_cmd;
        r_read_bit   <= n_read_bit;
        r_status     <= n_status;
        r_touched    <= n_touched;
    end

    // Next state, memory controls and result loading.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_left       = r_left;
        n_first_word = r_first_word;
        n_cmd        = r_cmd;
        n_out_valid  = r_out_valid && i_out_stall;
        n_read_bit   = r_read_bit;
        n_status     = r_status;
        n_touched    = r_touched;
        rd_en        = 1'b0;
        rd_addr      = i_addr;
        wr_en        = 1'b0;
        wr_data      = '0;

        unique case (r_state)
            S_INIT: begin
                // Zero the store after reset, one word a cycle.
                wr_en = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd        = i_cmd;
                    n_left       = i_span_count;
                    n_first_word = 1'b1;
                    if (i_cmd.kind == K_CLEAR) begin
                        n_addr  = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_addr  = i_addr;
                        rd_en   = !i_cmd.reject;
                        n_state = (i_cmd.kind == K_SPAN && !i_cmd.reject) ? S_SPAN : S_WORD;
                    end
                end
            end
            S_WORD: begin
                // Write back the modified word of a set or combine and post the result.
                wr_data = word_res;
                if (slot_free) begin
                    wr_en       = !r_cmd.reject &&
                                  (r_cmd.kind == K_SET || r_cmd.kind == K_COMBINE);
                    n_out_valid = 1'b1;
                    n_read_bit  = (r_cmd.kind == K_GET && !r_cmd.reject) ? rd_data[sh] : 1'b0;
                    n_status    = r_cmd.reject;
                    n_touched   = '0;
                    n_state     = S_IDLE;
                end
            end
            S_SPAN: begin
                // OR ones into the current word while reading the next one, if any.
                wr_data = rd_data | fill_m;
                if (!last_word) begin
                    wr_en        = 1'b1;
                    rd_en        = 1'b1;
                    rd_addr      = r_addr + AW'(1);
                    n_addr       = r_addr + AW'(1);
                    n_left       = r_left - WIW'(1);
                    n_first_word = 1'b0;
                end else if (slot_free) begin
                    wr_en       = 1'b1;
                    n_out_valid = 1'b1;
                    n_read_bit  = 1'b0;
                    n_status    = 1'b0;
                    n_touched   = r_cmd.touched;
                    n_state     = S_IDLE;
                end
            end
            S_CLEAR: begin
                // Zero the whole store; the result follows the last word.
                wr_en = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_read_bit  = 1'b0;
                        n_status    = 1'b0;
                        n_touched   = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_read_bit      = r_read_bit;
    assign o_status        = r_status;
    assign o_words_touched = r_touched;

    // A write and a read in the same cycle never address the same word.
    a_no_same_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (r_addr != rd_addr))
        else $error("store read and write collide on one word");

    // A rejected single-word command leaves the store untouched.
    a_reject_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WORD && r_cmd.reject) |-> !wr_en)
        else $error("rejected command wrote the store");

    // The span walk steps one word per cycle until its last word.
    a_span_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPAN && r_left != '0) |=>
        (r_state == S_SPAN && r_left == $past(r_left) - WIW'(1)
         && r_addr == $past(r_addr) + AW'(1)))
        else $error("span walk skipped or stalled");

    // The reset sweep ends in idle after the last word.
    a_init_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT && r_addr == LAST_ADDR) |=> (r_state == S_IDLE))
        else $error("reset sweep did not finish");

endmodule

FILE: rtl/packed_bitmap_draw_engine_top.sv
// Top level of the packed bitmap draw engine: configuration registers, decoder and sequencer.
//
// Usage:
// - Command channel (i_in_valid / o_in_stall): one command per transfer, each field a port.
//   Every command gives exactly one result on the result channel.
// - Result channel (o_out_valid / i_out_stall): read bit, status and words touched.
// - Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is high,
//   only while no command is in flight.
// - Set, get and combine commands read one store word; set and combine write it back,
//   and the result register loads once it frees. A rejected command skips the store.
// - A span fill ORs ones into one store word per cycle; its last word waits for the
//   result register to free.
// - Clear all zeroes one store word per cycle; its result follows the last word.
// - After reset the store is zeroed by a sweep over every word with o_in_stall high;
//   configuration writes are taken meanwhile.
// - One command is worked on at a time; o_in_stall is low only while the sequencer is idle.
// - A finished result waits in the output register while i_out_stall is high, and the
//   next command may already be taken; its result is held back until the register frees.
module packed_bitmap_draw_engine_top #(
    parameter int unsigned MAX_ROW_WORDS = pbde_pkg::MAX_ROW_WORDS_DEF,
    parameter int unsigned MAX_ROWS      = pbde_pkg::MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbde_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbde_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_mode,
    input  logic [12:0]                     i_pos_x,
    input  logic [12:0]                     i_pos_y,
    input  logic signed [11:0]              i_span_length,
    input  logic                            i_pixel_value,
    input  logic [31:0]                     i_source_word,
    input  logic [2:0]                      i_raster_op,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_read_bit,
    output logic                            o_status,
    output logic [5:0]                      o_words_touched
);

    import pbde_pkg::*;

    localparam int unsigned DEPTH = MAX_ROWS * MAX_ROW_WORDS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WIW   = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;

    logic [11:0]    r_origin_x;
    logic [11:0]    r_origin_y;
    logic [5:0]     r_width_words;
    logic [10:0]    r_height_rows;
    t_cmd           cmd;
    logic [AW-1:0]  cmd_addr;
    logic [WIW-1:0] span_count;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_width_words <= 6'd32;
            r_height_rows <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X:    r_origin_x    <= i_cfg_data;
                CFG_ORIGIN_Y:    r_origin_y    <= i_cfg_data;
                CFG_WIDTH_WORDS: r_width_words <= i_cfg_data[5:0];
                CFG_HEIGHT_ROWS: r_height_rows <= i_cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    // Command decode.
    pbde_decode #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS),
        .MAX_ROWS      (MAX_ROWS)
    ) u_decode (
        .i_origin_x    (r_origin_x),
        .i_origin_y    (r_origin_y),
        .i_width_words (r_width_words),
        .i_height_rows (r_height_rows),
        .i_mode        (i_mode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_span_length (i_span_length),
        .i_pixel_value (i_pixel_value),
        .i_source_word (i_source_word),
        .i_raster_op   (i_raster_op),
        .o_cmd         (cmd),
        .o_addr        (cmd_addr),
        .o_span_count  (span_count)
    );

    // Store sequencer and result register.
    pbde_ctrl #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS),
        .MAX_ROWS      (MAX_ROWS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (cmd),
        .i_addr          (cmd_addr),
        .i_span_count    (span_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_bit      (o_read_bit),
        .o_status        (o_status),
        .o_words_touched (o_words_touched)
    );

endmodule

FILE: tb/tb_packed_bitmap_draw_engine_top.sv
// Self-checking testbench for the packed bitmap draw engine: directed and random commands.
`timescale 1ns / 1ps

module tb_packed_bitmap_draw_engine_top;
    import pbde_pkg::*;

    // Codes outside the defined command and raster operation sets.
    localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;
    localparam logic [2:0] ROP_UNUSED_FIRST  = 3'd6;
    localparam logic [2:0] ROP_UNUSED_LAST   = 3'd7;

    localparam int ROW_STRIDE  = MAX_ROW_WORDS_DEF;
    localparam int STORE_WORDS = MAX_ROW_WORDS_DEF * MAX_ROWS_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int REPORT_MAX  = 10;

    // One draw command as presented on the command channel.
    typedef struct {
        logic [2:0]  mode;
        logic [12:0] pos_x;
        logic [12:0] pos_y;
        logic [11:0] span_length;
        logic        pixel_value;
        logic [31:0] source_word;
        logic [2:0]  raster_op;
    } t_draw_cmd;

    // One result as returned on the result channel.
    typedef struct {
        logic       read_bit;
        logic       status;
        logic [5:0] words_touched;
    } t_draw_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [2:0]            i_mode;
    logic [12:0]           i_pos_x;
    logic [12:0]           i_pos_y;
    logic signed [11:0]    i_span_length;
    logic                  i_pixel_value;
    logic [31:0]           i_source_word;
    logic [2:0]            i_raster_op;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_read_bit;
    logic                  o_status;
    logic [5:0]            o_words_touched;

    // Mirror of the bitmap and of the geometry registers.
    logic [31:0]  bitmap_words [0:STORE_WORDS-1];
    logic [11:0]  geom_origin_x;
    logic [11:0]  geom_origin_y;
    logic [5:0]   geom_width_words;
    logic [10:0]  geom_height_rows;

    t_draw_result expected_results [$];
    int           mismatch_count;
    int           result_count;
    int           cycle_count;
    int           idle_pct;
    int           stall_pct;

    packed_bitmap_draw_engine_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_span_length   (i_span_length),
        .i_pixel_value   (i_pixel_value),
        .i_source_word   (i_source_word),
        .i_raster_op     (i_raster_op),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_read_bit      (o_read_bit),
        .o_status        (o_status),
        .o_words_touched (o_words_touched)
    );

    // Clock with an 8 ns period.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run guard: a stuck handshake ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result receiver stalls at random, changing only on the falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Geometry in use, with oversized values clamped to the store size.
    function automatic int row_words_in_use();
        return (geom_width_words > MAX_ROW_WORDS_DEF) ? MAX_ROW_WORDS_DEF
                                                      : int'(geom_width_words);
    endfunction

    function automatic int rows_in_use();
        return (geom_height_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(geom_height_rows);
    endfunction

    // Compute the result of one command and apply its effect to the bitmap mirror.
    function automatic t_draw_result predict_draw_result(input t_draw_cmd c);
        t_draw_result r;
        int           rx;
        int           ry;
        int           len;
        int           cols;
        int           rows;
        int           base;
        int           rest;
        int           first;
        int           full;
        int           idx;
        bit           inside_map;
        logic [31:0]  mask;
        r.read_bit      = 1'b0;
        r.status        = 1'b1;
        r.words_touched = '0;
        rx   = int'(c.pos_x) - int'(geom_origin_x);
        ry   = int'(c.pos_y) - int'(geom_origin_y);
        len  = int'($signed(c.span_length));
        cols = row_words_in_use() * 32;
        rows = rows_in_use();
        inside_map = (rx >= 0) && (ry >= 0) && (rx < cols) && (ry < rows);
        idx = inside_map ? (ry * ROW_STRIDE + rx / 32) : 0;
        case (c.mode)
            MODE_SET: begin
                if (inside_map) begin
                    bitmap_words[idx][31 - rx % 32] = c.pixel_value;
                    r.status = 1'b0;
                end
            end
            MODE_GET: begin
                if (inside_map) begin
                    r.read_bit = bitmap_words[idx][31 - rx % 32];
                    r.status   = 1'b0;
                end
            end
            MODE_SPAN: begin
                if (ry >= 0 && ry < rows && len > 0) begin
                    // A start left of the bitmap moves to its edge; the length is kept.
                    if (rx < 0) rx = 0;
                    if (rx < cols) begin
                        if (rx + len >= cols) len = cols - rx;
                        rest  = rx % 32;
                        first = rx / 32;
                        base  = ry * ROW_STRIDE;
                        if (len < 32 - rest) begin
                            mask = (ALL_ONES << (32 - len)) >> rest;
                            bitmap_words[base + first] |= mask;
                        end else begin
                            bitmap_words[base + first] |= ALL_ONES >> rest;
                            len  = len - (32 - rest);
                            full = len / 32;
                            rest = len % 32;
                            for (int i = 1; i <= full; i++)
                                bitmap_words[base + first + i] = ALL_ONES;
                            if (rest != 0) begin
                                mask = ALL_ONES << (32 - rest);
                                bitmap_words[base + first + full + 1] |= mask;
                            end
                            r.words_touched = full[5:0];
                        end
                        r.status = 1'b0;
                    end
                end
            end
            MODE_COMBINE: begin
                if (inside_map && c.raster_op <= ROP_NOT) begin
                    case (c.raster_op)
                        ROP_COPY: bitmap_words[idx] = c.source_word;
                        ROP_OR:   bitmap_words[idx] = bitmap_words[idx] | c.source_word;
                        ROP_AND:  bitmap_words[idx] = bitmap_words[idx] & c.source_word;
                        ROP_XOR:  bitmap_words[idx] = bitmap_words[idx] ^ c.source_word;
                        ROP_ANDN: bitmap_words[idx] = bitmap_words[idx] & ~c.source_word;
                        default:  bitmap_words[idx] = ~c.source_word;
                    endcase
                    r.status = 1'b0;
                end
            end
            MODE_CLEAR: begin
                // The whole store is cleared, not only the part in use.
                foreach (bitmap_words[i]) bitmap_words[i] = '0;
                r.status = 1'b0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_draw_cmd make_cmd(input logic [2:0] mode, input int x, input int y,
                                           input int len, input logic pix,
                                           input logic [31:0] src, input logic [2:0] rop);
        t_draw_cmd c;
        c.mode        = mode;
        c.pos_x       = x[12:0];
        c.pos_y       = y[12:0];
        c.span_length = len[11:0];
        c.pixel_value = pix;
        c.source_word = src;
        c.raster_op   = rop;
        return c;
    endfunction

    // Random command, mostly aimed inside the bitmap in use, some at its edges.
    function automatic t_draw_cmd random_cmd();
        t_draw_cmd c;
        int        cols;
        int        rows;
        int        sel;
        int        x;
        int        y;
        int        len;
        cols = row_words_in_use() * 32;
        rows = rows_in_use();
        if (cols == 0) cols = 1;
        if (rows == 0) rows = 1;

        sel = $urandom_range(99);
        if (sel < 26)      c.mode = MODE_SET;
        else if (sel < 52) c.mode = MODE_GET;
        else if (sel < 72) c.mode = MODE_SPAN;
        else if (sel < 95) c.mode = MODE_COMBINE;
        else               c.mode = 3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));

        sel = $urandom_range(99);
        if (sel < 80) begin
            x = int'(geom_origin_x) + int'($urandom_range(cols - 1));
            y = int'(geom_origin_y) + int'($urandom_range(rows - 1));
        end else if (sel < 92) begin
            x = int'(geom_origin_x) + ($urandom_range(1) ? cols : 0) - 3
                + int'($urandom_range(5));
            y = int'(geom_origin_y) + ($urandom_range(1) ? rows : 0) - 3
                + int'($urandom_range(5));
        end else begin
            x = int'($urandom_range(8191));
            y = int'($urandom_range(8191));
        end
        if (x < 0) x = 0;
        if (y < 0) y = 0;
        if (x > 8191) x = 8191;
        if (y > 8191) y = 8191;

        sel = $urandom_range(99);
        if (sel < 70)      len = int'($urandom_range(cols + 8, 1));
        else if (sel < 85) len = int'($urandom_range(40, 1));
        else if (sel < 93) len = -int'($urandom_range(2048));
        else               len = int'($urandom_range(4095));

        c.pos_x       = x[12:0];
        c.pos_y       = y[12:0];
        c.span_length = len[11:0];
        c.pixel_value = 1'($urandom_range(1));
        c.source_word = $urandom();
        if ($urandom_range(99) < 88)
            c.raster_op = 3'($urandom_range(ROP_NOT, ROP_COPY));
        else
            c.raster_op = 3'($urandom_range(ROP_UNUSED_LAST, ROP_UNUSED_FIRST));
        return c;
    endfunction

    // Present one command and wait for its transfer; entered and left on a falling edge.
    task automatic send_cmd(input t_draw_cmd c);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= c.mode;
        i_pos_x       <= c.pos_x;
        i_pos_y       <= c.pos_y;
        i_span_length <= c.span_length;
        i_pixel_value <= c.pixel_value;
        i_source_word <= c.source_word;
        i_raster_op   <= c.raster_op;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_draw_result(c));
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) send_cmd(random_cmd());
    endtask

    // Hold off the command channel until every result is back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all four geometry registers on consecutive cycles; only while idle.
    task automatic set_geometry(input int ox, input int oy, input int w, input int h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ORIGIN_X;
        i_cfg_data  <= ox[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_ORIGIN_Y;
        i_cfg_data  <= oy[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_WIDTH_WORDS;
        i_cfg_data  <= w[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_HEIGHT_ROWS;
        i_cfg_data  <= h[CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we         <= 1'b0;
        geom_origin_x    = ox[11:0];
        geom_origin_y    = oy[11:0];
        geom_width_words = w[5:0];
        geom_height_rows = h[10:0];
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("result %0d: %s expected %0h, got %0h", result_count, field, want, got);
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_draw_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: read_bit %0h status %0h words_touched %0h",
                             o_read_bit, o_status, o_words_touched);
            end else begin
                want = expected_results.pop_front();
                if (o_read_bit !== want.read_bit)
                    note_mismatch("read_bit", 32'(want.read_bit), 32'(o_read_bit));
                if (o_status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_words_touched !== want.words_touched)
                    note_mismatch("words_touched", 32'(want.words_touched),
                                  32'(o_words_touched));
            end
            result_count++;
        end
    end

    // Pixel corners, every span case and every raster operation on default geometry.
    task automatic test_directed_basics();
        idle_pct  = 0;
        stall_pct = 0;
        set_geometry(0, 0, MAX_ROW_WORDS_DEF, MAX_ROWS_DEF);
        send_cmd(make_cmd(MODE_SET, 0, 0, 0, 1'b1, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SET, 1023, 1023, 0, 1'b1, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 0, 0, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 1023, 1023, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 1024, 0, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 0, 1024, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SET, 8191, 8191, 0, 1'b1, '1, ROP_COPY));
        send_cmd(make_cmd(MODE_SET, 0, 0, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 0, 0, 0, 1'b0, '0, ROP_COPY));
        // Bad lengths, a span inside one word, one over several words, one cut at the row end, one past it.
        send_cmd(make_cmd(MODE_SPAN, 3, 5, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 3, 5, -1, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 3, 5, -2048, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 3, 5, 10, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 40, 5, 100, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 1000, 6, 2047, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 1024, 6, 4, 1'b0, '0, ROP_COPY));
        // Every raster operation on one word, then the two unused codes.
        send_cmd(make_cmd(MODE_COMBINE, 64, 9, 0, 1'b0, 32'ha5a5_a5a5, ROP_COPY));
        send_cmd(make_cmd(MODE_COMBINE, 70, 9, 0, 1'b0, 32'h0f0f_0f0f, ROP_OR));
        send_cmd(make_cmd(MODE_COMBINE, 95, 9, 0, 1'b0, 32'hff00_ff00, ROP_AND));
        send_cmd(make_cmd(MODE_COMBINE, 64, 9, 0, 1'b0, 32'hffff_ffff, ROP_XOR));
        send_cmd(make_cmd(MODE_COMBINE, 64, 9, 0, 1'b0, 32'h1234_5678, ROP_ANDN));
        send_cmd(make_cmd(MODE_GET, 66, 9, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_COMBINE, 64, 9, 0, 1'b0, 32'h0000_0000, ROP_NOT));
        send_cmd(make_cmd(MODE_COMBINE, 64, 9, 0, 1'b0, 32'h0000_0000, ROP_UNUSED_FIRST));
        send_cmd(make_cmd(MODE_COMBINE, 64, 9, 0, 1'b0, 32'hffff_ffff, ROP_UNUSED_LAST));
        drain_results();
    endtask

    // A full-row span, then clear all, then the unused mode codes.
    task automatic test_clear_and_unused_modes();
        send_cmd(make_cmd(MODE_SPAN, 0, 0, 2047, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SET, 500, 700, 0, 1'b1, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_CLEAR, 8191, 8191, 2047, 1'b1, '1, ROP_UNUSED_LAST));
        send_cmd(make_cmd(MODE_GET, 500, 700, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 0, 0, 0, 1'b0, '0, ROP_COPY));
        for (int m = int'(MODE_UNUSED_FIRST); m <= int'(MODE_UNUSED_LAST); m++)
            send_cmd(make_cmd(m[2:0], 0, 0, 1, 1'b1, '1, ROP_COPY));
        drain_results();
    endtask

    // Register extremes: largest origin with one word and one row, zero size, oversize.
    task automatic test_geometry_extremes();
        idle_pct  = 25;
        stall_pct = 25;
        set_geometry(4095, 4095, 1, 1);
        send_cmd(make_cmd(MODE_SET, 4095, 4095, 0, 1'b1, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 4095, 4095, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 4127, 4095, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 4094, 4095, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 4000, 4095, 100, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 8191, 8191, 2047, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_COMBINE, 4100, 4095, 0, 1'b0, $urandom(), ROP_XOR));
        send_random(15);
        drain_results();

        // Zero width and height leave no pixels at all.
        set_geometry(0, 0, 0, 0);
        send_cmd(make_cmd(MODE_SET, 0, 0, 0, 1'b1, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 0, 0, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 0, 0, 5, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_COMBINE, 0, 0, 0, 1'b0, '1, ROP_COPY));
        send_random(5);
        drain_results();

        // Width and height above the store size are clamped to it.
        set_geometry(100, 7, 63, 2047);
        send_cmd(make_cmd(MODE_GET, 1123, 1030, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_GET, 1124, 7, 0, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_SPAN, 50, 9, 2047, 1'b0, '0, ROP_COPY));
        send_cmd(make_cmd(MODE_COMBINE, 1123, 1030, 0, 1'b0, $urandom(), ROP_NOT));
        send_random(15);
        drain_results();
    endtask

    // One random phase with its own geometry, a clear in the middle and periodic hold-offs.
    task automatic run_random_phase(input int idle, input int stall, input int count);
        int w;
        int h;
        if ($urandom_range(99) < 70) begin
            w = $urandom_range(3, 1);
            h = $urandom_range(16, 1);
        end else begin
            w = $urandom_range(MAX_ROW_WORDS_DEF, 1);
            h = $urandom_range(MAX_ROWS_DEF, 1);
        end
        set_geometry($urandom_range(4095), $urandom_range(4095), w, h);
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                send_cmd(make_cmd(MODE_CLEAR, $urandom_range(8191), $urandom_range(8191),
                                  0, 1'b0, $urandom(), ROP_COPY));
            if (n % 160 == 159) drain_results();
            send_cmd(random_cmd());
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 460);
        run_random_phase(60, 0, 460);
        run_random_phase(0, 60, 460);
        run_random_phase(34, 34, 460);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_ORIGIN_X;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_mode           = MODE_SET;
        i_pos_x          = '0;
        i_pos_y          = '0;
        i_span_length    = '0;
        i_pixel_value    = 1'b0;
        i_source_word    = '0;
        i_raster_op      = ROP_COPY;
        i_out_stall      = 1'b0;
        idle_pct         = 0;
        stall_pct        = 0;
        mismatch_count   = 0;
        result_count     = 0;
        geom_origin_x    = '0;
        geom_origin_y    = '0;
        geom_width_words = 6'd32;
        geom_height_rows = 11'd1024;
        foreach (bitmap_words[i]) bitmap_words[i] = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_basics();
        test_clear_and_unused_modes();
        test_geometry_extremes();
        test_random_traffic();

        // Wait out everything still in flight, then allow for the longest span.
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
